// ===== rtl/qwt_pkg.sv =====
// ----------------------------------------------------------------------------
// qwt_pkg
// Shared types, constants and helpers for the quoted whitespace tokenizer.
// ----------------------------------------------------------------------------
package qwt_pkg;

  // Position and token count widths
  localparam int POS_BITS   = 16;
  localparam int COUNT_BITS = 10;
  localparam int MAXT_BITS  = 10;
  localparam int CMP_BITS   = (COUNT_BITS > MAXT_BITS) ? COUNT_BITS : MAXT_BITS;

  localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Stream payload widths
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_DATA_BITS  = 2 * COUNT_BITS + 2 * POS_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPACE_CHARS  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_QUOTES  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_QUOTES = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_QUOTE_COUNT  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TOKENS   = 3'd5;

  // Register reset values: space, tab, newline; single and double quotes
  localparam logic [31:0]          RST_SPACE_CHARS  = 32'h000A_0920;
  localparam logic [2:0]           RST_SPACE_COUNT  = 3'd3;
  localparam logic [15:0]          RST_OPEN_QUOTES  = 16'h2227;
  localparam logic [15:0]          RST_CLOSE_QUOTES = 16'h2227;
  localparam logic [1:0]           RST_QUOTE_COUNT  = 2'd2;
  localparam logic [MAXT_BITS-1:0] RST_MAX_TOKENS   = 10'd400;

  // Input kinds
  localparam logic IN_CHAR = 1'b0;
  localparam logic IN_END  = 1'b1;

  // Result kinds
  localparam logic [1:0] OUT_TOKEN = 2'd0;
  localparam logic [1:0] OUT_DONE  = 2'd1;
  localparam logic [1:0] OUT_ERROR = 2'd2;

  // Output queue
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_PLAIN  = 4'b0010,
    MODE_QUOTED = 4'b0100,
    MODE_FULL   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [31:0]          space_chars;
    logic [2:0]           space_count;
    logic [15:0]          open_quotes;
    logic [15:0]          close_quotes;
    logic [1:0]           quote_count;
    logic [MAXT_BITS-1:0] max_tokens;
  } cfg_t;

  typedef struct packed {
    logic is_space;
    logic open_hit;
    logic open_slot;
    logic close_hit;
  } match_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [COUNT_BITS-1:0] idx;
    logic [POS_BITS-1:0]   start;
    logic [POS_BITS-1:0]   len;
    logic [COUNT_BITS-1:0] total;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Saturating position increment
  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/qwt_match.sv =====
// ----------------------------------------------------------------------------
// qwt_match
// Character classifier: whitespace set, opening quote slot, closing quote.
// ----------------------------------------------------------------------------
module qwt_match (
  input  qwt_pkg::cfg_t   cfg,
  input  logic [7:0]      ch,
  input  logic            quote_slot,
  output qwt_pkg::match_t m
);

  logic [3:0] sp_hit;
  logic [1:0] oq_hit;

  // Whitespace slots; a count above four simply enables all four
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sp_hit[i] = (cfg.space_count > 3'(i)) && (cfg.space_chars[8*i +: 8] == ch);
    end
  end

  // Opening quote slots, slot 0 has priority
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      oq_hit[i] = (cfg.quote_count > 2'(i)) && (cfg.open_quotes[8*i +: 8] == ch);
    end
  end

  assign m.is_space  = |sp_hit;
  assign m.open_hit  = |oq_hit;
  assign m.open_slot = ~oq_hit[0];
  assign m.close_hit = quote_slot ? (cfg.close_quotes[15:8] == ch)
                                  : (cfg.close_quotes[7:0] == ch);

endmodule

// ===== rtl/qwt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// qwt_out_fifo
// Small result queue: takes up to two results per cycle, gives one per cycle while popped.
// ----------------------------------------------------------------------------
module qwt_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  qwt_pkg::push_t   push,
  input  logic             pop,
  output qwt_pkg::result_t head,
  output logic             head_valid,
  output logic             room2
);

  qwt_pkg::result_t                mem [qwt_pkg::QDEPTH];
  logic [qwt_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [qwt_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [qwt_pkg::QCNT_BITS-1:0]   cnt;
  logic [qwt_pkg::QCNT_BITS-1:0]   cnt_next;
  logic                            do_pop;

  assign do_pop   = pop && (cnt != '0);
  assign cnt_next = cnt + qwt_pkg::QCNT_BITS'(push.n)
                  - qwt_pkg::QCNT_BITS'(do_pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + qwt_pkg::QPTR_BITS'(push.n);
      rd_ptr <= rd_ptr + qwt_pkg::QPTR_BITS'(do_pop);
      cnt    <= cnt_next;
    end
  end

  // Storage, two write slots
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.r1;
    end
  end

  assign head       = mem[rd_ptr];
  assign head_valid = (cnt != '0);
  assign room2      = (cnt <= qwt_pkg::QCNT_BITS'(qwt_pkg::QDEPTH - 2));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (32'(cnt) + 32'(push.n) <= qwt_pkg::QDEPTH))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= qwt_pkg::QDEPTH)
    else $error("result queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd1 && !do_pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("result queue count did not follow a single push");
`endif

endmodule

// ===== rtl/qwt_core.sv =====
// ----------------------------------------------------------------------------
// qwt_core
// Configuration registers, per-string tokenizer state and result building.
// ----------------------------------------------------------------------------
module qwt_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [qwt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [qwt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               accept,
  input  logic                               kind,
  input  logic [7:0]                         ch,
  output qwt_pkg::push_t                     push
);

  qwt_pkg::cfg_t                    cfg;
  qwt_pkg::match_t                  m;
  qwt_pkg::mode_t                   mode, mode_next;
  logic [qwt_pkg::POS_BITS-1:0]     char_pos, char_pos_next;
  logic [qwt_pkg::POS_BITS-1:0]     tok_start, tok_start_next;
  logic [qwt_pkg::POS_BITS-1:0]     tok_length, tok_length_next;
  logic                             quote_slot, quote_slot_next;
  logic [qwt_pkg::COUNT_BITS-1:0]   tok_count, tok_count_next;
  logic [qwt_pkg::COUNT_BITS-1:0]   cnt_inc;
  logic                             limit_hit;
  qwt_pkg::result_t                 tok_res;
  qwt_pkg::push_t                   push_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.space_chars  <= qwt_pkg::RST_SPACE_CHARS;
      cfg.space_count  <= qwt_pkg::RST_SPACE_COUNT;
      cfg.open_quotes  <= qwt_pkg::RST_OPEN_QUOTES;
      cfg.close_quotes <= qwt_pkg::RST_CLOSE_QUOTES;
      cfg.quote_count  <= qwt_pkg::RST_QUOTE_COUNT;
      cfg.max_tokens   <= qwt_pkg::RST_MAX_TOKENS;
    end else if (cfg_we) begin
      case (cfg_index)
        qwt_pkg::REG_SPACE_CHARS:  cfg.space_chars  <= cfg_data[31:0];
        qwt_pkg::REG_SPACE_COUNT:  cfg.space_count  <= cfg_data[2:0];
        qwt_pkg::REG_OPEN_QUOTES:  cfg.open_quotes  <= cfg_data[15:0];
        qwt_pkg::REG_CLOSE_QUOTES: cfg.close_quotes <= cfg_data[15:0];
        qwt_pkg::REG_QUOTE_COUNT:  cfg.quote_count  <= cfg_data[1:0];
        qwt_pkg::REG_MAX_TOKENS:   cfg.max_tokens   <= cfg_data[qwt_pkg::MAXT_BITS-1:0];
        default: ;
      endcase
    end
  end

  qwt_match u_match (
    .cfg        (cfg),
    .ch         (ch),
    .quote_slot (quote_slot),
    .m          (m)
  );

  // Token finish: count advance and limit check
  assign cnt_inc   = (tok_count == qwt_pkg::COUNT_MAX) ? tok_count : tok_count + 1'b1;
  assign limit_hit = (qwt_pkg::CMP_BITS'(cnt_inc) >= qwt_pkg::CMP_BITS'(cfg.max_tokens))
                  || (cnt_inc == qwt_pkg::COUNT_MAX);

  always_comb begin
    tok_res       = '0;
    tok_res.kind  = qwt_pkg::OUT_TOKEN;
    tok_res.idx   = tok_count;
    tok_res.start = tok_start;
    tok_res.len   = tok_length;
  end

  // Next state and results of one item
  always_comb begin
    mode_next       = mode;
    char_pos_next   = char_pos;
    tok_start_next  = tok_start;
    tok_length_next = tok_length;
    quote_slot_next = quote_slot;
    tok_count_next  = tok_count;
    push_next       = '0;

    if (accept) begin
      if (kind == qwt_pkg::IN_END) begin
        // End of string: report, then clear per-string state
        if (mode == qwt_pkg::MODE_QUOTED) begin
          push_next.n        = 2'd1;
          push_next.r0.kind  = qwt_pkg::OUT_ERROR;
          push_next.r0.idx   = tok_count;
          push_next.r0.start = tok_start;
          push_next.r0.last  = 1'b1;
        end else if (mode == qwt_pkg::MODE_PLAIN) begin
          push_next.n        = 2'd2;
          push_next.r0       = tok_res;
          push_next.r1.kind  = qwt_pkg::OUT_DONE;
          push_next.r1.total = cnt_inc;
          push_next.r1.last  = 1'b1;
        end else begin
          push_next.n        = 2'd1;
          push_next.r0.kind  = qwt_pkg::OUT_DONE;
          push_next.r0.total = tok_count;
          push_next.r0.last  = 1'b1;
        end
        mode_next       = qwt_pkg::MODE_IDLE;
        char_pos_next   = '0;
        tok_start_next  = '0;
        tok_length_next = '0;
        quote_slot_next = 1'b0;
        tok_count_next  = '0;
      end else begin
        case (mode)
          qwt_pkg::MODE_IDLE: begin
            if (!m.is_space) begin
              if (m.open_hit) begin
                quote_slot_next = m.open_slot;
                tok_start_next  = qwt_pkg::sat_inc(char_pos);
                tok_length_next = '0;
                mode_next       = qwt_pkg::MODE_QUOTED;
              end else begin
                tok_start_next  = char_pos;
                tok_length_next = qwt_pkg::POS_BITS'(1);
                mode_next       = qwt_pkg::MODE_PLAIN;
              end
            end
          end
          qwt_pkg::MODE_PLAIN, qwt_pkg::MODE_QUOTED: begin
            // Plain ends at whitespace, quoted at its closing quote
            if ((mode == qwt_pkg::MODE_PLAIN) ? m.is_space : m.close_hit) begin
              push_next.n    = 2'd1;
              push_next.r0   = tok_res;
              tok_count_next = cnt_inc;
              mode_next      = limit_hit ? qwt_pkg::MODE_FULL : qwt_pkg::MODE_IDLE;
            end else begin
              tok_length_next = qwt_pkg::sat_inc(tok_length);
            end
          end
          default: ;
        endcase
        char_pos_next = qwt_pkg::sat_inc(char_pos);
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= qwt_pkg::MODE_IDLE;
      char_pos   <= '0;
      tok_start  <= '0;
      tok_length <= '0;
      quote_slot <= 1'b0;
      tok_count  <= '0;
    end else begin
      mode       <= mode_next;
      char_pos   <= char_pos_next;
      tok_start  <= tok_start_next;
      tok_length <= tok_length_next;
      quote_slot <= quote_slot_next;
      tok_count  <= tok_count_next;
    end
  end

  assign push = push_next;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == qwt_pkg::IN_END) |=>
      (mode == qwt_pkg::MODE_IDLE && char_pos == '0 && tok_count == '0))
    else $error("string state not cleared after end item");

  a_full_sticks: assert property (@(posedge clk) disable iff (rst)
    (mode == qwt_pkg::MODE_FULL && !(accept && kind == qwt_pkg::IN_END)) |=>
      (mode == qwt_pkg::MODE_FULL && $stable(tok_count)))
    else $error("token limit state left without end item");

  a_two_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (accept && kind == qwt_pkg::IN_END
                          && mode == qwt_pkg::MODE_PLAIN))
    else $error("two results outside an end item");
`endif

endmodule

// ===== rtl/quoted_whitespace_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_whitespace_tokenizer
// Splits a character stream into whitespace or quote delimited tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one character per transfer, s_tdata = ch, s_tuser = kind
//   (0 character, 1 end of string). Output stream m_*: one result per
//   transfer, m_tuser = out_kind, m_tlast = last, m_tdata = token_index,
//   start_pos, token_len, token_total from the low bit up.
//   A token result is queued when the character that closes it is accepted, and
//   reaches m_* from the result queue. An end item that closes a plain token
//   gives two results (token, then done) in that order.
//   Throughput is one item per cycle, set by the single state update per
//   character and a result queue of four entries; s_tready drops while the
//   queue holds more than two results, i.e. only when m_tready is held low.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect on the
//   next cycle; the user must make them while the stream is idle: the block has no check for this.
//   Reset (rst, synchronous) loads the default registers (space, tab,
//   newline; single and double quotes; 400 tokens), clears the string state
//   and empties the result queue.
// ----------------------------------------------------------------------------
module quoted_whitespace_tokenizer (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [qwt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [qwt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [qwt_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // [7:0] ch
  input  logic                                 s_tuser,   // [0] kind
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [qwt_pkg::OUT_TDATA_BITS-1:0]   m_tdata,   // token_index, start_pos,
                                                          // token_len, token_total, pad
  output logic [1:0]                           m_tuser,   // [1:0] out_kind
  output logic                                 m_tlast    // last
);

  qwt_pkg::push_t   push;
  qwt_pkg::result_t head;
  logic             head_valid;
  logic             room2;
  logic             accept;

  assign s_tready = room2;
  assign accept   = s_tvalid && room2;

  qwt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (s_tuser),
    .ch        (s_tdata[7:0]),
    .push      (push)
  );

  qwt_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (m_tready),
    .head       (head),
    .head_valid (head_valid),
    .room2      (room2)
  );

  // Result packing, first field in the low bits, zero padded
  assign m_tvalid = head_valid;
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;
  assign m_tdata  = qwt_pkg::OUT_TDATA_BITS'({head.total, head.len, head.start, head.idx});

endmodule
